/* sv/keyed_floor_ceiling_table_unit_defines.svh */
// Assertion macros for the keyed floor/ceiling table unit.
// Used by the checker; no other dependencies.
`ifndef KEYED_FLOOR_CEILING_TABLE_UNIT_DEFINES_SVH
`define KEYED_FLOOR_CEILING_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KFCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KFCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/kfct_pkg.sv */
// Shared types and codes for the keyed floor/ceiling table unit.
// No dependencies.
package kfct_pkg;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_EXACT  = 3'd2;
    localparam logic [2:0] KIND_FLOOR  = 3'd3;
    localparam logic [2:0] KIND_CEIL   = 3'd4;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_DUP    = 2'd2;
    localparam logic [1:0] STATUS_ABSENT = 2'd3;

    // Control flags carried by the search token along the cell row.
    typedef struct packed {
        logic active;   // token present at this stage
        logic hfound;   // request handle seen in a valid cell so far
        logic exact;    // exact key match found so far
        logic best;     // floor or ceiling candidate found so far
    } tok_flags_t;

    // Broadcast update applied to all cells at the end of a request.
    typedef struct packed {
        logic insert_go;
        logic remove_go;
    } commit_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

/* sv/keyed_floor_ceiling_table_unit.sv */
// Top level of the keyed floor/ceiling table: request control, cell row, result register.
// Depends on kfct_pkg and kfct_cell.
//
//   channel   signals                            direction   accepted when
//   request   req_valid/req_stall, kind,          in          req_valid && !req_stall
//             entry_handle, entry_key
//   response  rsp_valid/rsp_stall, status,        out         rsp_valid && !rsp_stall
//             found, match_handle, match_key
//
// Flow: one request at a time; the next request is taken once the finished
// request has written the result register and the unit is back in idle. The
// search token walks the cell row one cell per cycle.
// Reset: rst_n clears all valid bits at once; the table starts empty.
// Stalls: a waiting result does not block the next request; a finished request
// holds before its update until the result register is free.
module keyed_floor_ceiling_table_unit #(
    parameter int ENTRIES     = 16,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [2:0]             kind,
    input  logic [HANDLE_BITS-1:0] entry_handle,
    input  logic [KEY_BITS-1:0]    entry_key,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [1:0]             status,
    output logic                   found,
    output logic [HANDLE_BITS-1:0] match_handle,
    output logic [KEY_BITS-1:0]    match_key
);
    import kfct_pkg::*;

    state_t state_reg, state_next;

    // Token stages: index 0 is the launch register, index i+1 is cell i's output.
    tok_flags_t             tok_flags       [ENTRIES+1];
    logic [2:0]             tok_kind        [ENTRIES+1];
    logic [HANDLE_BITS-1:0] tok_handle      [ENTRIES+1];
    logic [KEY_BITS-1:0]    tok_key         [ENTRIES+1];
    logic [HANDLE_BITS-1:0] tok_best_handle [ENTRIES+1];
    logic [KEY_BITS-1:0]    tok_best_key    [ENTRIES+1];

    logic                   ent_valid  [ENTRIES];
    logic [HANDLE_BITS-1:0] ent_handle [ENTRIES];
    logic [KEY_BITS-1:0]    ent_key    [ENTRIES];

    logic                   launch_active_reg;
    logic [2:0]             launch_kind_reg;
    logic [HANDLE_BITS-1:0] launch_handle_reg;
    logic [KEY_BITS-1:0]    launch_key_reg;

    // Finished token, held until the update and result can go out.
    tok_flags_t             fin_flags_reg;
    logic [2:0]             fin_kind_reg;
    logic [HANDLE_BITS-1:0] fin_handle_reg;
    logic [KEY_BITS-1:0]    fin_key_reg;
    logic [HANDLE_BITS-1:0] fin_best_handle_reg;
    logic [KEY_BITS-1:0]    fin_best_key_reg;

    logic                   rsp_valid_reg;
    logic [1:0]             status_reg, status_next;
    logic                   found_reg, found_next;
    logic [HANDLE_BITS-1:0] match_handle_reg, match_handle_next;
    logic [KEY_BITS-1:0]    match_key_reg, match_key_next;

    commit_t commit;
    logic    req_accept;
    logic    slot_free;
    logic    finish_go;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign finish_go  = (state_reg == ST_FINISH) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Token has left the last cell.
                if (tok_flags[ENTRIES].active)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            launch_active_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            launch_active_reg <= req_accept;
        end
    end

    // Capture the request into the launch stage.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            launch_kind_reg   <= kind;
            launch_handle_reg <= entry_handle;
            launch_key_reg    <= entry_key;
        end
    end

    always_comb
    begin
        tok_flags[0]        = '0;
        tok_flags[0].active = launch_active_reg;
        tok_kind[0]         = launch_kind_reg;
        tok_handle[0]       = launch_handle_reg;
        tok_key[0]          = launch_key_reg;
        tok_best_handle[0]  = '0;
        tok_best_key[0]     = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic                   lv;
            logic [HANDLE_BITS-1:0] lh;
            logic [KEY_BITS-1:0]    lk;
            logic                   rv;
            logic [HANDLE_BITS-1:0] rh;
            logic [KEY_BITS-1:0]    rk;

            // Newest cell takes the inserted entry.
            if (gi == 0)
            begin : g_head
                assign lv = 1'b1;
                assign lh = fin_handle_reg;
                assign lk = fin_key_reg;
            end
            else
            begin : g_left
                assign lv = ent_valid[gi-1];
                assign lh = ent_handle[gi-1];
                assign lk = ent_key[gi-1];
            end

            // Oldest cell empties on a remove.
            if (gi == ENTRIES-1)
            begin : g_tail
                assign rv = 1'b0;
                assign rh = '0;
                assign rk = '0;
            end
            else
            begin : g_right
                assign rv = ent_valid[gi+1];
                assign rh = ent_handle[gi+1];
                assign rk = ent_key[gi+1];
            end

            kfct_cell #(
                .KEY_BITS    (KEY_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk                 (clk),
                .rst_n               (rst_n),
                .tok_in_flags        (tok_flags[gi]),
                .tok_in_kind         (tok_kind[gi]),
                .tok_in_handle       (tok_handle[gi]),
                .tok_in_key          (tok_key[gi]),
                .tok_in_best_handle  (tok_best_handle[gi]),
                .tok_in_best_key     (tok_best_key[gi]),
                .tok_out_flags       (tok_flags[gi+1]),
                .tok_out_kind        (tok_kind[gi+1]),
                .tok_out_handle      (tok_handle[gi+1]),
                .tok_out_key         (tok_key[gi+1]),
                .tok_out_best_handle (tok_best_handle[gi+1]),
                .tok_out_best_key    (tok_best_key[gi+1]),
                .commit              (commit),
                .left_valid          (lv),
                .left_handle         (lh),
                .left_key            (lk),
                .right_valid         (rv),
                .right_handle        (rh),
                .right_key           (rk),
                .ent_valid           (ent_valid[gi]),
                .ent_handle          (ent_handle[gi]),
                .ent_key             (ent_key[gi])
            );
        end
    endgenerate

    // Hold the finished token while the result register is busy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_flags_reg <= '0;
        end
        else if ((state_reg == ST_SCAN) && tok_flags[ENTRIES].active)
        begin
            fin_flags_reg <= tok_flags[ENTRIES];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SCAN) && tok_flags[ENTRIES].active)
        begin
            fin_kind_reg        <= tok_kind[ENTRIES];
            fin_handle_reg      <= tok_handle[ENTRIES];
            fin_key_reg         <= tok_key[ENTRIES];
            fin_best_handle_reg <= tok_best_handle[ENTRIES];
            fin_best_key_reg    <= tok_best_key[ENTRIES];
        end
    end

    // Decide the result and the table update from the finished token.
    always_comb
    begin
        commit            = '0;
        status_next       = STATUS_OK;
        found_next        = 1'b0;
        match_handle_next = '0;
        match_key_next    = '0;
        unique case (fin_kind_reg) inside
            KIND_INSERT:
            begin
                // Duplicate handle is checked before fullness.
                if (fin_flags_reg.hfound)
                begin
                    status_next = STATUS_DUP;
                end
                else if (ent_valid[ENTRIES-1])
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    commit.insert_go = finish_go;
                end
            end
            KIND_REMOVE:
            begin
                if (!fin_flags_reg.hfound)
                begin
                    status_next = STATUS_ABSENT;
                end
                else
                begin
                    commit.remove_go = finish_go;
                end
            end
            KIND_EXACT, KIND_FLOOR, KIND_CEIL:
            begin
                // The cells only set best for floor and ceiling searches.
                if (fin_flags_reg.exact || fin_flags_reg.best)
                begin
                    found_next        = 1'b1;
                    match_handle_next = fin_best_handle_reg;
                    match_key_next    = fin_best_key_reg;
                end
            end
            default:
            begin
                // Unused kinds: no operation, all fields zero.
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            status_reg       <= status_next;
            found_reg        <= found_next;
            match_handle_reg <= match_handle_next;
            match_key_reg    <= match_key_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign match_handle = match_handle_reg;
    assign match_key    = match_key_reg;

endmodule

/* sv/kfct_cell.sv */
// One table cell: holds one handle/key entry and one stage of the search token.
// Depends on kfct_pkg.
module kfct_cell #(
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kfct_pkg::tok_flags_t   tok_in_flags,
    input  logic [2:0]             tok_in_kind,
    input  logic [HANDLE_BITS-1:0] tok_in_handle,
    input  logic [KEY_BITS-1:0]    tok_in_key,
    input  logic [HANDLE_BITS-1:0] tok_in_best_handle,
    input  logic [KEY_BITS-1:0]    tok_in_best_key,
    output kfct_pkg::tok_flags_t   tok_out_flags,
    output logic [2:0]             tok_out_kind,
    output logic [HANDLE_BITS-1:0] tok_out_handle,
    output logic [KEY_BITS-1:0]    tok_out_key,
    output logic [HANDLE_BITS-1:0] tok_out_best_handle,
    output logic [KEY_BITS-1:0]    tok_out_best_key,
    input  kfct_pkg::commit_t      commit,
    input  logic                   left_valid,
    input  logic [HANDLE_BITS-1:0] left_handle,
    input  logic [KEY_BITS-1:0]    left_key,
    input  logic                   right_valid,
    input  logic [HANDLE_BITS-1:0] right_handle,
    input  logic [KEY_BITS-1:0]    right_key,
    output logic                   ent_valid,
    output logic [HANDLE_BITS-1:0] ent_handle,
    output logic [KEY_BITS-1:0]    ent_key
);
    import kfct_pkg::*;

    logic                   valid_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic                   pull_reg;

    tok_flags_t             flags_reg, flags_next;
    logic [2:0]             kind_reg;
    logic [HANDLE_BITS-1:0] req_handle_reg;
    logic [KEY_BITS-1:0]    req_key_reg;
    logic [HANDLE_BITS-1:0] best_handle_reg, best_handle_next;
    logic [KEY_BITS-1:0]    best_key_reg, best_key_next;

    logic self_hit;
    logic key_eq;
    logic floor_take;
    logic ceil_take;

    always_comb
    begin
        self_hit   = valid_reg && (handle_reg == tok_in_handle);
        key_eq     = valid_reg && (key_reg == tok_in_key);
        floor_take = valid_reg && (tok_in_kind == KIND_FLOOR) && (key_reg < tok_in_key)
                     && (!tok_in_flags.best || (key_reg > tok_in_best_key));
        ceil_take  = valid_reg && (tok_in_kind == KIND_CEIL) && (key_reg > tok_in_key)
                     && (!tok_in_flags.best || (key_reg < tok_in_best_key));

        flags_next        = tok_in_flags;
        flags_next.hfound = tok_in_flags.hfound || self_hit;
        best_handle_next  = tok_in_best_handle;
        best_key_next     = tok_in_best_key;
        // Once an exact match is held, later (older) cells cannot displace it.
        if (tok_in_flags.active && !tok_in_flags.exact)
        begin
            if (key_eq)
            begin
                flags_next.exact = 1'b1;
                best_handle_next = handle_reg;
                best_key_next    = key_reg;
            end
            else if (floor_take || ceil_take)
            begin
                flags_next.best  = 1'b1;
                best_handle_next = handle_reg;
                best_key_next    = key_reg;
            end
        end
    end

    // Advance the token one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            pull_reg  <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (tok_in_flags.active)
            begin
                pull_reg <= flags_next.hfound;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= tok_in_kind;
        req_handle_reg  <= tok_in_handle;
        req_key_reg     <= tok_in_key;
        best_handle_reg <= best_handle_next;
        best_key_reg    <= best_key_next;
    end

    // Shift the entry: toward older cells on insert, toward newer ones from
    // the removed cell onward on remove.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (commit.insert_go)
        begin
            valid_reg <= left_valid;
        end
        else if (commit.remove_go && pull_reg)
        begin
            valid_reg <= right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.insert_go)
        begin
            handle_reg <= left_handle;
            key_reg    <= left_key;
        end
        else if (commit.remove_go && pull_reg)
        begin
            handle_reg <= right_handle;
            key_reg    <= right_key;
        end
    end

    assign tok_out_flags       = flags_reg;
    assign tok_out_kind        = kind_reg;
    assign tok_out_handle      = req_handle_reg;
    assign tok_out_key         = req_key_reg;
    assign tok_out_best_handle = best_handle_reg;
    assign tok_out_best_key    = best_key_reg;
    assign ent_valid           = valid_reg;
    assign ent_handle          = handle_reg;
    assign ent_key             = key_reg;

endmodule

/* sv/kfct_checker.sv */
// Port-level checks for the keyed floor/ceiling table unit, bound to the top level.
// Depends on kfct_pkg and keyed_floor_ceiling_table_unit_defines.svh.
`include "keyed_floor_ceiling_table_unit_defines.svh"

module kfct_checker #(
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_stall,
    input logic                   rsp_valid,
    input logic                   rsp_stall,
    input logic [1:0]             status,
    input logic                   found,
    input logic [HANDLE_BITS-1:0] match_handle,
    input logic [KEY_BITS-1:0]    match_key
);
    import kfct_pkg::*;

    // A stalled result holds.
    `KFCT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(found) && $stable(match_handle) && $stable(match_key), "stalled response changed")

    // One request at a time: an accepted request closes the input.
    `KFCT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && !req_stall, req_stall, "request taken while busy")

    // A hit is only reported with ok status.
    `KFCT_ASSERT_IMPL(a_found_ok, clk, rst_n, rsp_valid && found, status == STATUS_OK, "found with error status")

    // No hit leaves the match fields at zero.
    `KFCT_ASSERT_IMPL(a_miss_zero, clk, rst_n, rsp_valid && !found, (match_handle == '0) && (match_key == '0), "miss with nonzero match")

endmodule

bind keyed_floor_ceiling_table_unit kfct_checker #(
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_kfct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .found        (found),
    .match_handle (match_handle),
    .match_key    (match_key)
);

/* tb/tb_top.sv */
// Self-checking testbench for keyed_floor_ceiling_table_unit: a built-in table predictor,
// directed and random request streams, and random gaps and stalls on both channels.
// Depends on kfct_pkg and the unit's RTL.
module tb_top;

    import kfct_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 8;

    // Kind codes the unit treats as no operation.
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    // Worst case per request is one table walk, the longest sender gap and the longest
    // response stall; take the limit several times over that for about a thousand requests.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    key;
    } table_result_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   req_valid    = 1'b0;
    logic                   req_stall;
    logic [2:0]             kind         = KIND_EXACT;
    logic [HANDLE_BITS-1:0] entry_handle = '0;
    logic [KEY_BITS-1:0]    entry_key    = '0;
    logic                   rsp_valid;
    logic                   rsp_stall    = 1'b0;
    logic [1:0]             status;
    logic                   found;
    logic [HANDLE_BITS-1:0] match_handle;
    logic [KEY_BITS-1:0]    match_key;

    keyed_floor_ceiling_table_unit #(
        .ENTRIES     (ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .entry_handle (entry_handle),
        .entry_key    (entry_key),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .found        (found),
        .match_handle (match_handle),
        .match_key    (match_key)
    );

    // Predicted table contents, newest entry in cell 0, valid cells form a prefix.
    logic                   model_valid  [ENTRIES];
    logic [HANDLE_BITS-1:0] model_handle [ENTRIES];
    logic [KEY_BITS-1:0]    model_key    [ENTRIES];

    // Results predicted for accepted requests, oldest first.
    table_result_t pending_results[$];
    table_result_t oldest_result;

    logic [HANDLE_BITS-1:0] handle_pool [24];
    logic [KEY_BITS-1:0]    key_pool    [8];

    bit idle_off = 1'b0;   // set for stretches with no gaps and no stalls
    int stall_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int responses_checked = 0;
    int inserts_sent = 0, removes_sent = 0, searches_sent = 0, spares_sent = 0;
    int full_seen = 0, dup_seen = 0, absent_seen = 0, search_hits = 0, search_misses = 0;

    // Free-running clock, period 8.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: stop a hung run with the fail message.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("[keyed_floor_ceiling_table_unit] ERROR");
            $finish;
        end
    end

    // Print one line per mismatch (up to a cap) and count it.
    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (error_count < PRINT_CAP)
            $display("mismatch, response %0d: %s expected %0h got %0h",
                     responses_checked, what, want, got);
        error_count++;
    endtask

    function automatic int find_handle(input logic [HANDLE_BITS-1:0] h);
        for (int i = 0; i < ENTRIES; i++)
            if (model_valid[i] && model_handle[i] == h)
                return i;
        return -1;
    endfunction

    function automatic int table_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (model_valid[i])
                n++;
        return n;
    endfunction

    // Apply one request to the predicted table and return the response it must produce.
    function automatic table_result_t apply_to_table(input logic [2:0] op,
                                                     input logic [HANDLE_BITS-1:0] h,
                                                     input logic [KEY_BITS-1:0] k);
        table_result_t res;
        int pos;
        int pick;
        int hit;
        res = '0;
        case (op)
            KIND_INSERT:
            begin
                inserts_sent++;
                pos = find_handle(h);
                // A duplicate handle is reported ahead of a full table.
                if (pos >= 0)
                begin
                    res.status = STATUS_DUP;
                    dup_seen++;
                end
                else if (model_valid[ENTRIES-1])
                begin
                    res.status = STATUS_FULL;
                    full_seen++;
                end
                else
                begin
                    for (int i = ENTRIES - 1; i > 0; i--)
                    begin
                        model_valid[i]  = model_valid[i-1];
                        model_handle[i] = model_handle[i-1];
                        model_key[i]    = model_key[i-1];
                    end
                    model_valid[0]  = 1'b1;
                    model_handle[0] = h;
                    model_key[0]    = k;
                end
            end
            KIND_REMOVE:
            begin
                removes_sent++;
                pos = find_handle(h);
                if (pos < 0)
                begin
                    res.status = STATUS_ABSENT;
                    absent_seen++;
                end
                else
                begin
                    // Close the gap toward the newest end.
                    for (int i = pos; i < ENTRIES - 1; i++)
                    begin
                        model_valid[i]  = model_valid[i+1];
                        model_handle[i] = model_handle[i+1];
                        model_key[i]    = model_key[i+1];
                    end
                    model_valid[ENTRIES-1]  = 1'b0;
                    model_handle[ENTRIES-1] = '0;
                    model_key[ENTRIES-1]    = '0;
                end
            end
            KIND_EXACT, KIND_FLOOR, KIND_CEIL:
            begin
                searches_sent++;
                pick = -1;
                hit  = -1;
                // Scan newest first; strict compares keep the newest among equal keys.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (model_valid[i])
                    begin
                        if (model_key[i] == k)
                        begin
                            hit = i;
                            break;
                        end
                        if (op == KIND_FLOOR && model_key[i] < k &&
                            (pick < 0 || model_key[i] > model_key[pick]))
                            pick = i;
                        if (op == KIND_CEIL && model_key[i] > k &&
                            (pick < 0 || model_key[i] < model_key[pick]))
                            pick = i;
                    end
                end
                if (op == KIND_EXACT)
                    pick = -1;
                if (hit >= 0)
                    pick = hit;
                if (pick >= 0)
                begin
                    res.found  = 1'b1;
                    res.handle = model_handle[pick];
                    res.key    = model_key[pick];
                    search_hits++;
                end
                else
                    search_misses++;
            end
            default:
                spares_sent++;
        endcase
        return res;
    endfunction

    // Sender gap: mostly none or short, a few long.
    function automatic int gap_cycles();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Send one request and predict its response at the edge where it is accepted.
    // Valid stays high on return so back-to-back requests never drop it in between.
    task automatic issue_request(input logic [2:0] op, input logic [HANDLE_BITS-1:0] h,
                                 input logic [KEY_BITS-1:0] k);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        kind         <= op;
        entry_handle <= h;
        entry_key    <= k;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(apply_to_table(op, h, k));
    endtask

    // Hold off the sender until every predicted response has come back.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Response stall: runs of random length, mostly short, now and then a long one.
    always @(posedge clk)
    begin
        int r;
        if (!rst_n || idle_off)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                rsp_stall <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else if (r < 90)
            begin
                rsp_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else if (r < 97)
            begin
                rsp_stall <= 1'b1;
                stall_left = $urandom_range(3, 11);
            end
            else
            begin
                rsp_stall <= 1'b1;
                stall_left = $urandom_range(19, 59);
            end
        end
    end

    // Compare every accepted response, field by field, with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no request pending, status", 0, status);
            else
            begin
                oldest_result = pending_results.pop_front();
                if (status !== oldest_result.status)
                    report_mismatch("status", oldest_result.status, status);
                if (found !== oldest_result.found)
                    report_mismatch("found", oldest_result.found, found);
                if (match_handle !== oldest_result.handle)
                    report_mismatch("match_handle", oldest_result.handle, match_handle);
                if (match_key !== oldest_result.key)
                    report_mismatch("match_key", oldest_result.key, match_key);
            end
            responses_checked++;
        end
    end

    // Key choice: near keys in the table, a small shared pool, extremes, or anything.
    function automatic logic [KEY_BITS-1:0] choose_key();
        int cnt;
        int r;
        logic [KEY_BITS-1:0] base;
        cnt = table_count();
        r = $urandom_range(0, 99);
        if (cnt > 0 && r < 45)
        begin
            base = model_key[$urandom_range(0, cnt - 1)];
            case ($urandom_range(0, 2))
                0:       return base - 1'b1;
                1:       return base;
                default: return base + 1'b1;
            endcase
        end
        if (r < 60)
            return key_pool[$urandom_range(0, 7)];
        if (r < 70)
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return {{(KEY_BITS-1){1'b0}}, 1'b1};
                2:       return {{(KEY_BITS-1){1'b1}}, 1'b0};
                default: return '1;
            endcase
        return $urandom();
    endfunction

    // Handle choice: removes mostly hit live entries, inserts sometimes repeat one.
    function automatic logic [HANDLE_BITS-1:0] choose_handle(input bit for_remove);
        int cnt;
        int r;
        cnt = table_count();
        r = $urandom_range(0, 99);
        if (cnt > 0 && r < (for_remove ? 60 : 15))
            return model_handle[$urandom_range(0, cnt - 1)];
        if (r < 80)
            return handle_pool[$urandom_range(0, 23)];
        return HANDLE_BITS'($urandom_range(0, 255));
    endfunction

    // One phase of random requests with the given insert, remove and spare weights.
    task automatic random_phase(input int count, input int w_ins, input int w_rem,
                                input int w_spare);
        int r;
        logic [2:0] op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < w_ins)
                op = KIND_INSERT;
            else if (r < w_ins + w_rem)
                op = KIND_REMOVE;
            else if (r < w_ins + w_rem + w_spare)
                op = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else
                op = 3'($urandom_range(KIND_EXACT, KIND_CEIL));
            if (op == KIND_INSERT || op == KIND_REMOVE)
                issue_request(op, choose_handle(op == KIND_REMOVE), choose_key());
            else
                issue_request(op, 8'($urandom_range(0, 255)), choose_key());
        end
        // Let the pipeline drain before the next phase changes the mix.
        wait_for_results();
    endtask

    // Searches and removes on an empty table, and the spare kinds.
    task automatic test_empty_table();
        issue_request(KIND_EXACT,     8'h00, 32'h0000_0000);
        issue_request(KIND_FLOOR,     8'hFF, 32'hFFFF_FFFF);
        issue_request(KIND_CEIL,      8'h55, 32'h0000_0000);
        issue_request(KIND_REMOVE,    8'h00, 32'h0000_0000);
        issue_request(KIND_REMOVE,    8'hFF, 32'hFFFF_FFFF);
        issue_request(KIND_SPARE_LO,  8'hAA, 32'h5555_5555);
        issue_request(KIND_SPARE_MID, 8'h55, 32'hAAAA_AAAA);
        issue_request(KIND_SPARE_HI,  8'hFF, 32'hFFFF_FFFF);
    endtask

    // Extreme keys and handles, exact precedence, newest among equal keys,
    // duplicate insert, and removal of a handle that is gone.
    task automatic test_extreme_keys();
        issue_request(KIND_INSERT, 8'h00, 32'h0000_0000);
        issue_request(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
        issue_request(KIND_FLOOR,  8'h00, 32'hFFFF_FFFE);
        issue_request(KIND_CEIL,   8'h00, 32'h0000_0001);
        issue_request(KIND_EXACT,  8'h3C, 32'hFFFF_FFFF);
        issue_request(KIND_FLOOR,  8'hC3, 32'h0000_0000);
        issue_request(KIND_CEIL,   8'h00, 32'hFFFF_FFFF);
        issue_request(KIND_INSERT, 8'h07, 32'h0000_0000);
        issue_request(KIND_EXACT,  8'h00, 32'h0000_0000);
        issue_request(KIND_FLOOR,  8'h00, 32'h1234_5678);
        issue_request(KIND_INSERT, 8'hFF, 32'h0000_0005);
        issue_request(KIND_REMOVE, 8'h00, 32'h0000_0000);
        issue_request(KIND_REMOVE, 8'h00, 32'h0000_0000);
        issue_request(KIND_SPARE_HI, 8'hFF, 32'h0000_0000);
    endtask

    // Fill the table to capacity with no idling, then push on the full table.
    task automatic test_full_table();
        logic [HANDLE_BITS-1:0] h;
        wait_for_results();
        idle_off = 1'b1;
        while (table_count() < ENTRIES)
        begin
            do
                h = HANDLE_BITS'($urandom_range(0, 255));
            while (find_handle(h) >= 0);
            issue_request(KIND_INSERT, h, ($urandom_range(0, 3) == 0) ? model_key[0] : $urandom());
        end
        do
            h = HANDLE_BITS'($urandom_range(0, 255));
        while (find_handle(h) >= 0);
        issue_request(KIND_INSERT, h, $urandom());
        // Duplicate on a full table must report the duplicate, not the fullness.
        issue_request(KIND_INSERT, model_handle[ENTRIES/2], $urandom());
        issue_request(KIND_EXACT,  8'h00, model_key[ENTRIES-1]);
        issue_request(KIND_FLOOR,  8'h00, '1);
        issue_request(KIND_CEIL,   8'h00, '0);
        issue_request(KIND_REMOVE, model_handle[ENTRIES-1], '0);
        issue_request(KIND_REMOVE, model_handle[0], '0);
        issue_request(KIND_REMOVE, h, '0);
        wait_for_results();
        idle_off = 1'b0;
    endtask

    // Random traffic: growth, churn, shrink, an idle-free stretch, and noisy requests.
    task automatic test_random_mix();
        for (int i = 0; i < 24; i++)
            handle_pool[i] = HANDLE_BITS'($urandom_range(0, 255));
        for (int i = 0; i < 8; i++)
            key_pool[i] = (i < 4) ? KEY_BITS'($urandom_range(0, 15)) : KEY_BITS'($urandom());
        random_phase(200, 65, 15, 2);
        random_phase(250, 40, 30, 3);
        random_phase(150, 20, 55, 2);
        idle_off = 1'b1;
        random_phase(150, 40, 30, 3);
        idle_off = 1'b0;
        random_phase(200, 35, 30, 10);
    endtask

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            model_valid[i]  = 1'b0;
            model_handle[i] = '0;
            model_key[i]    = '0;
        end
        // Hold reset at the start, then release it once for the whole run.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extreme_keys();
        test_full_table();
        test_random_mix();

        // Drain, then give the unit a full table walk and more to show stray responses.
        wait_for_results();
        repeat (2 * ENTRIES + 8) @(posedge clk);

        $display("covered %0d inserts, %0d removes, %0d searches, %0d spare kinds; %0d responses",
                 inserts_sent, removes_sent, searches_sent, spares_sent, responses_checked);
        $display("searches hit %0d missed %0d; full %0d, duplicate %0d, absent %0d",
                 search_hits, search_misses, full_seen, dup_seen, absent_seen);
        if (error_count == 0)
            $display("[keyed_floor_ceiling_table_unit] OK");
        else
            $display("[keyed_floor_ceiling_table_unit] ERROR");
        $finish;
    end

endmodule
